// File: rtl/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg
// shared types and constants of the first-fit segment allocator
// ----------------------------------------------------------------------------
package ffsa_pkg;

  localparam int MAX_SEGMENTS   = 1024;
  localparam int GRANULE        = 16;   // power of two
  localparam int IDX_W          = $clog2(MAX_SEGMENTS);
  localparam int CNT_W          = $clog2(MAX_SEGMENTS + 1);
  localparam logic [31:0] CAPACITY_RESET = 32'd16777216;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_FIT     = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
  localparam logic [2:0] ST_TABLE_FULL = 3'd3;
  localparam logic [2:0] ST_BAD_SIZE   = 3'd4;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] size_bytes;
    logic [31:0] region_offset;
  } ffsa_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] granted_offset;
  } ffsa_out_t;

  typedef struct packed {
    logic        free;
    logic [31:0] start;
    logic [31:0] length;
  } seg_entry_t;

endpackage

// File: rtl/ffsa_ram.sv
// ----------------------------------------------------------------------------
// ffsa_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module ffsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/first_fit_segment_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_unit
// first-fit allocator over an ordered segment table with coalescing on free
// ----------------------------------------------------------------------------
// usage:
//   in_valid/in_stall/in_item carry one request (allocate, free, query);
//   out_valid/out_stall/out_item return exactly one status item per request.
//   cfg_we/cfg_wdata set the capacity and reset the table to one free
//   segment; write only while no request is in flight.
// timing:
//   one request at a time; the segment table sits in a simple dual-port ram
//   and every step goes through its one read and one write port.
//   the first-fit or offset search reads, then checks, each entry visited; a
//   split shifts the later entries up one at a time, a merge shifts them down
//   one at a time, with setup and write-back states around them.
// reset:
//   synchronous active-low; after reset the block writes entry 0 in S_INIT,
//   then takes items. a result waiting under out_stall holds the block.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator_unit
  import ffsa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ffsa_in_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output ffsa_out_t out_item,
  input  logic      cfg_we,
  input  logic [31:0] cfg_wdata
);

  typedef enum logic [15:0] {
    S_IDLE    = 16'h0001,
    S_INIT    = 16'h0002,
    S_SCAN_RD = 16'h0004,
    S_SCAN_CK = 16'h0008,
    S_SU_RD   = 16'h0010,
    S_SU_WR   = 16'h0020,
    S_SPLIT   = 16'h0040,
    S_NX_RD   = 16'h0080,
    S_NX_CK   = 16'h0100,
    S_SD_RD   = 16'h0200,
    S_SD_WR   = 16'h0400,
    S_PV_RD   = 16'h0800,
    S_PV_CK   = 16'h1000,
    S_FIN_WR  = 16'h2000,
    S_DONE    = 16'h4000,
    S_BAD     = 16'h8000
  } state_t;

  state_t           state_r, state_nxt;
  logic [31:0]      cap_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] tgt_r, tgt_nxt;
  logic             phase_r, phase_nxt;
  ffsa_in_t         req_r;
  logic [31:0]      want_r, want_nxt;
  seg_entry_t       cur_r, cur_nxt;
  seg_entry_t       split_r, split_nxt;
  logic [2:0]       stat_r, stat_nxt;
  logic [31:0]      grant_r, grant_nxt;
  logic             out_valid_r;
  ffsa_out_t        out_item_r;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  seg_entry_t       ram_wdata, ram_rdata;
  logic [$bits(seg_entry_t)-1:0] ram_rbits;

  logic [32:0] sum33, want33;
  logic [31:0] rem;
  logic        in_acc;

  assign ram_rdata = seg_entry_t'(ram_rbits);

  ffsa_ram #(
    .WIDTH ($bits(seg_entry_t)),
    .DEPTH (MAX_SEGMENTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rbits)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign sum33  = {1'b0, in_item.size_bytes} + 33'(GRANULE - 1);
  assign want33 = sum33 & ~33'(GRANULE - 1);
  assign rem    = ram_rdata.length - want_r;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ptr_nxt   = ptr_r;
    tgt_nxt   = tgt_r;
    phase_nxt = phase_r;
    want_nxt  = want_r;
    cur_nxt   = cur_r;
    split_nxt = split_r;
    stat_nxt  = stat_r;
    grant_nxt = grant_r;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = cur_r;
    ram_raddr = ptr_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (cfg_we) begin
          ram_we    = 1'b1;
          ram_wdata = '{free: 1'b1, start: 32'd0, length: cfg_wdata};
          count_nxt = CNT_W'(1);
        end else if (in_acc) begin
          ptr_nxt   = '0;
          stat_nxt  = ST_NOT_FOUND;
          grant_nxt = '0;
          want_nxt  = want33[31:0];
          if (in_item.operation == OP_ALLOC) begin
            if (in_item.size_bytes == 32'd0 || want33[32]) begin
              stat_nxt  = ST_BAD_SIZE;
              state_nxt = S_DONE;
            end else begin
              stat_nxt  = ST_NO_FIT;
              state_nxt = S_SCAN_RD;
            end
          end else if (in_item.operation == OP_FREE ||
                       in_item.operation == OP_QUERY) begin
            state_nxt = S_SCAN_RD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = '{free: 1'b1, start: 32'd0, length: cap_r};
        state_nxt = S_IDLE;
      end
      S_SCAN_RD: begin
        state_nxt = S_SCAN_CK;
      end
      S_SCAN_CK: begin
        tgt_nxt = ptr_r;
        if (req_r.operation == OP_ALLOC) begin
          if (ram_rdata.free && ram_rdata.length >= want_r) begin
            grant_nxt = ram_rdata.start;
            stat_nxt  = ST_OK;
            if (rem > 32'(GRANULE)) begin
              if (count_r == CNT_W'(MAX_SEGMENTS)) begin
                stat_nxt  = ST_TABLE_FULL;
                grant_nxt = '0;
                state_nxt = S_DONE;
              end else begin
                cur_nxt   = '{free: 1'b0, start: ram_rdata.start, length: want_r};
                split_nxt = '{free: 1'b1, start: ram_rdata.start + want_r,
                              length: rem};
                ptr_nxt   = count_r;
                state_nxt = S_SU_RD;
              end
            end else begin
              cur_nxt   = '{free: 1'b0, start: ram_rdata.start,
                            length: ram_rdata.length};
              state_nxt = S_FIN_WR;
            end
          end else if (ptr_r + 1'b1 == count_r) begin
            state_nxt = S_DONE;
          end else begin
            ptr_nxt   = ptr_r + 1'b1;
            state_nxt = S_SCAN_RD;
          end
        end else begin
          if (ram_rdata.start == req_r.region_offset) begin
            stat_nxt = ST_OK;
            if (req_r.operation == OP_FREE) begin
              cur_nxt   = '{free: 1'b1, start: ram_rdata.start,
                            length: ram_rdata.length};
              state_nxt = S_NX_RD;
            end else begin
              state_nxt = S_DONE;
            end
          end else if (ptr_r + 1'b1 == count_r) begin
            state_nxt = S_DONE;
          end else begin
            ptr_nxt   = ptr_r + 1'b1;
            state_nxt = S_SCAN_RD;
          end
        end
      end
      // shift entries up to open a slot after the granted one
      S_SU_RD: begin
        ram_raddr = IDX_W'(ptr_r - 1'b1);
        if (ptr_r > tgt_r + 1'b1) begin
          state_nxt = S_SU_WR;
        end else begin
          state_nxt = S_SPLIT;
        end
      end
      S_SU_WR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r[IDX_W-1:0];
        ram_wdata = ram_rdata;
        ptr_nxt   = ptr_r - 1'b1;
        state_nxt = S_SU_RD;
      end
      S_SPLIT: begin
        ram_we    = 1'b1;
        ram_waddr = IDX_W'(tgt_r + 1'b1);
        ram_wdata = split_r;
        count_nxt = count_r + 1'b1;
        state_nxt = S_FIN_WR;
      end
      S_NX_RD: begin
        ram_raddr = IDX_W'(tgt_r + 1'b1);
        if (tgt_r + 1'b1 < count_r) begin
          state_nxt = S_NX_CK;
        end else begin
          state_nxt = S_PV_RD;
        end
      end
      S_NX_CK: begin
        if (ram_rdata.free) begin
          cur_nxt.length = cur_r.length + ram_rdata.length;
          ptr_nxt   = tgt_r + 1'b1;
          phase_nxt = 1'b0;
          state_nxt = S_SD_RD;
        end else begin
          state_nxt = S_PV_RD;
        end
      end
      // shift entries down to drop the entry at ptr
      S_SD_RD: begin
        ram_raddr = IDX_W'(ptr_r + 1'b1);
        if (ptr_r + 1'b1 < count_r) begin
          state_nxt = S_SD_WR;
        end else begin
          count_nxt = count_r - 1'b1;
          state_nxt = phase_r ? S_FIN_WR : S_PV_RD;
        end
      end
      S_SD_WR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r[IDX_W-1:0];
        ram_wdata = ram_rdata;
        ptr_nxt   = ptr_r + 1'b1;
        state_nxt = S_SD_RD;
      end
      S_PV_RD: begin
        ram_raddr = IDX_W'(tgt_r - 1'b1);
        if (tgt_r != '0) begin
          state_nxt = S_PV_CK;
        end else begin
          state_nxt = S_FIN_WR;
        end
      end
      S_PV_CK: begin
        if (ram_rdata.free) begin
          cur_nxt   = '{free: 1'b1, start: ram_rdata.start,
                        length: ram_rdata.length + cur_r.length};
          ptr_nxt   = tgt_r;
          tgt_nxt   = tgt_r - 1'b1;
          phase_nxt = 1'b1;
          state_nxt = S_SD_RD;
        end else begin
          state_nxt = S_FIN_WR;
        end
      end
      S_FIN_WR: begin
        ram_we    = 1'b1;
        ram_waddr = tgt_r[IDX_W-1:0];
        ram_wdata = cur_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cap_r       <= CAPACITY_RESET;
      count_r     <= CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (state_r == S_IDLE && cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r   <= ptr_nxt;
    tgt_r   <= tgt_nxt;
    phase_r <= phase_nxt;
    want_r  <= want_nxt;
    cur_r   <= cur_nxt;
    split_r <= split_nxt;
    stat_r  <= stat_nxt;
    grant_r <= grant_nxt;
    if (in_acc) begin
      req_r <= in_item;
    end
    if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
      out_item_r <= '{status: stat_r, granted_offset: grant_r};
    end
  end

endmodule

// File: test/first_fit_segment_allocator_unit_tb.sv
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_unit_tb
// checks allocate, free, query and unused-opcode requests of the allocator
// against a table-level prediction, under random idling, stalls and
// several capacity settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module first_fit_segment_allocator_unit_tb;
  import ffsa_pkg::*;

  localparam int QUIET_LIMIT = 50000;
  localparam int DRAIN_CYCLES = 2 * 4 * MAX_SEGMENTS + 64;

  class alloc_scoreboard;
    logic [31:0] capacity;
    bit          seg_free[MAX_SEGMENTS];
    logic [31:0] seg_start[MAX_SEGMENTS];
    logic [31:0] seg_len[MAX_SEGMENTS];
    int          seg_count;
    ffsa_out_t   pending[$];
    int          errors;
    logic [31:0] live_offsets[$];

    function void init_table(logic [31:0] cap);
      capacity = cap;
      seg_count = 1;
      seg_free[0] = 1;
      seg_start[0] = 0;
      seg_len[0] = cap;
    endfunction

    function int find_offset(logic [31:0] off);
      for (int i = 0; i < seg_count; i++) begin
        if (seg_start[i] == off) return i;
      end
      return -1;
    endfunction

    function void coalesce();
      int i;
      i = 0;
      while (i + 1 < seg_count) begin
        if (seg_free[i] && seg_free[i+1]) begin
          seg_len[i] += seg_len[i+1];
          for (int j = i + 1; j + 1 < seg_count; j++) begin
            seg_free[j] = seg_free[j+1];
            seg_start[j] = seg_start[j+1];
            seg_len[j] = seg_len[j+1];
          end
          seg_count--;
        end else begin
          i++;
        end
      end
    endfunction

    function ffsa_out_t allocate(logic [31:0] size);
      ffsa_out_t r;
      logic [32:0] want;
      logic [31:0] rem;
      r.status = ST_NO_FIT;
      r.granted_offset = 0;
      want = ((33'(size) + GRANULE - 1) / GRANULE) * GRANULE;
      if (size == 0 || want[32]) begin
        r.status = ST_BAD_SIZE;
        return r;
      end
      for (int i = 0; i < seg_count; i++) begin
        if (!seg_free[i] || seg_len[i] < want[31:0]) continue;
        rem = seg_len[i] - want[31:0];
        if (rem > GRANULE) begin
          if (seg_count >= MAX_SEGMENTS) begin
            r.status = ST_TABLE_FULL;
            return r;
          end
          for (int j = seg_count; j > i + 1; j--) begin
            seg_free[j] = seg_free[j-1];
            seg_start[j] = seg_start[j-1];
            seg_len[j] = seg_len[j-1];
          end
          seg_count++;
          seg_len[i] = want[31:0];
          seg_free[i+1] = 1;
          seg_start[i+1] = seg_start[i] + want[31:0];
          seg_len[i+1] = rem;
        end
        seg_free[i] = 0;
        r.status = ST_OK;
        r.granted_offset = seg_start[i];
        live_offsets.push_back(seg_start[i]);
        return r;
      end
      return r;
    endfunction

    function void note_request(ffsa_in_t it);
      ffsa_out_t r;
      int k;
      r.status = ST_NOT_FOUND;
      r.granted_offset = 0;
      if (it.operation == OP_ALLOC) begin
        r = allocate(it.size_bytes);
      end else if (it.operation == OP_FREE) begin
        k = find_offset(it.region_offset);
        if (k >= 0) begin
          seg_free[k] = 1;
          coalesce();
          r.status = ST_OK;
        end
      end else if (it.operation == OP_QUERY) begin
        if (find_offset(it.region_offset) >= 0) r.status = ST_OK;
      end
      pending.push_back(r);
    endfunction

    function void check_result(ffsa_out_t got);
      ffsa_out_t want;
      if (pending.size() == 0) begin
        report("unexpected item", 0, got.status);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) report("status", want.status, got.status);
      if (got.granted_offset !== want.granted_offset)
        report("granted_offset", want.granted_offset, got.granted_offset);
    endfunction

    function void report(string what, logic [31:0] want, logic [31:0] got);
      errors++;
      $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $realtime);
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  ffsa_in_t  in_item;
  logic      out_valid;
  logic      out_stall;
  ffsa_out_t out_item;
  logic      cfg_we;
  logic [31:0] cfg_wdata;

  alloc_scoreboard sb;
  bit sender_idle_en;
  bit receiver_idle_en;
  bit hold_off;
  int quiet_cycles;

  first_fit_segment_allocator_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_request(in_item);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  always @(posedge clk) begin
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: random stall bursts, or a long hold-off when asked
  initial begin
    int n;
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1;
        repeat (300) @(negedge clk);
        out_stall <= 0;
        hold_off = 0;
      end else if (receiver_idle_en && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 7);
        out_stall <= 1;
        repeat (n) @(negedge clk);
        out_stall <= 0;
      end
    end
  end

  task automatic send(ffsa_in_t it);
    if (sender_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid <= 1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic request(logic [1:0] op, logic [31:0] size, logic [31:0] off);
    ffsa_in_t it;
    it.operation = op;
    it.size_bytes = size;
    it.region_offset = off;
    send(it);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_capacity(logic [31:0] cap);
    wait_drained();
    cfg_we <= 1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we <= 0;
    sb.init_table(cap);
  endtask

  function automatic logic [31:0] pick_offset();
    if (sb.live_offsets.size() != 0 && $urandom_range(0, 9) < 8)
      return sb.live_offsets[$urandom_range(0, sb.live_offsets.size() - 1)];
    return $urandom();
  endfunction

  function automatic logic [31:0] pick_size(logic [31:0] cap);
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return $urandom_range(0, 40);
      default: return $urandom_range(1, (cap >> 3) + 1);
    endcase
  endfunction

  task automatic random_run(int count, logic [31:0] cap);
    logic [1:0] op;
    for (int i = 0; i < count; i++) begin
      op = $urandom_range(0, 9) < 5 ? OP_ALLOC : ($urandom_range(0, 3) == 0 ? OP_QUERY :
           ($urandom_range(0, 9) == 0 ? 2'd3 : OP_FREE));
      request(op, pick_size(cap), pick_offset());
    end
  endtask

  initial begin
    sb = new();
    sb.init_table(CAPACITY_RESET);
    rst_n = 0;
    in_valid = 0;
    in_item = '0;
    cfg_we = 0;
    cfg_wdata = 0;
    quiet_cycles = 0;
    sender_idle_en = 1;
    receiver_idle_en = 1;
    hold_off = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed items on the reset capacity
    request(OP_ALLOC, 0, 0);
    request(OP_ALLOC, 32'hffff_ffff, 32'hffff_ffff);
    request(OP_ALLOC, 32'hffff_fff0, 0);
    request(OP_ALLOC, 1, 0);
    request(OP_ALLOC, 17, 0);
    request(OP_ALLOC, 32'h0100_0000, 0);
    request(OP_QUERY, 0, 16);
    request(OP_QUERY, 0, 5);
    request(OP_FREE, 0, 0);
    request(OP_FREE, 0, 0);
    request(OP_FREE, 0, 32'hffff_ffff);
    request(2'd3, 32'hffff_ffff, 0);
    request(OP_FREE, 0, 16);
    request(OP_ALLOC, 32'h00ff_ffe0, 0);
    request(OP_ALLOC, 16, 0);
    request(OP_ALLOC, 1, 0);

    set_capacity(32'd48);
    request(OP_ALLOC, 16, 0);
    request(OP_ALLOC, 16, 0);
    request(OP_ALLOC, 16, 0);
    request(OP_FREE, 0, 16);
    request(OP_ALLOC, 1, 0);
    set_capacity(32'd0);
    request(OP_ALLOC, 1, 0);
    request(OP_QUERY, 0, 0);

    // long hold-off so the block backs up
    hold_off = 1;
    random_run(10, 32'd16777216);

    set_capacity(32'hffff_fff0);
    random_run(60, 32'hffff_fff0);
    set_capacity(32'd16);
    random_run(20, 32'd16);
    set_capacity(32'd4096);
    random_run(70, 32'd4096);
    set_capacity(32'd65536);
    random_run(70, 32'd65536);

    // no idling at the end
    sender_idle_en = 0;
    receiver_idle_en = 0;
    random_run(50, 32'd65536);

    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
